[design/gfr_pkg.sv]
// gfr_pkg: shared types and codes for the axis Gaussian filter block.
// Used by gfr_ctrl, gfr_datapath and the top level. No dependencies.
package gfr_pkg;

    localparam logic [1:0] OP_TAP   = 2'd0;
    localparam logic [1:0] OP_VOXEL = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] CFG_AXIS   = 3'd0;
    localparam logic [2:0] CFG_RADIUS = 3'd1;
    localparam logic [2:0] CFG_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_DEPTH  = 3'd4;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 16;

    typedef logic signed [7:0] coord_t;

    typedef struct packed {
        logic       wr_tap;
        logic       wr_voxel;
        logic       load;
        logic       issue;
        logic [2:0] tap_idx;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic [2:0] last_tap;
        logic       out_free;
    } status_t;

    // Reflect once at the edges, then clamp into 0..n-1.
    function automatic coord_t mirror(coord_t i, logic [4:0] n);
        coord_t m;
        coord_t nn;
        nn = $signed({3'b000, n});
        m = i;
        if (i < 0) begin
            m = -i - 8'sd1;
        end else if (i >= nn) begin
            m = (nn <<< 1) - i - 8'sd1;
        end
        if (m < 0) begin
            m = '0;
        end
        if (m > nn - 8'sd1) begin
            m = nn - 8'sd1;
        end
        return m;
    endfunction

endpackage

[design/axis_gaussian_filter_reflect.sv]
// axis_gaussian_filter_reflect: top level of the axis Gaussian filter.
// Depends on gfr_pkg, gfr_ctrl, gfr_datapath (which holds gfr_ram).
//
// Holds a volume of Q3.13 samples and up to seven Q1.16 taps, and returns
// voxels filtered along the configured axis with reflected borders. Tap and
// voxel writes (tuser 0 and 1) leave s_tready high. A read (tuser 2) keeps
// s_tready low after acceptance while it makes one volume RAM read per tap
// on the single memory port, drains the multiply-accumulate pipeline and
// rounds into the result register. The result word waits in its own
// register, so a new word can be taken while it sits unread; a following
// read holds in its last state until the result register frees. The user must
// see that configuration is written only while idle; the block does not enforce it.
module axis_gaussian_filter_reflect #(
    parameter int MAX_WIDTH   = 16,
    parameter int MAX_HEIGHT  = 16,
    parameter int MAX_DEPTH   = 8,
    parameter int MAX_RADIUS  = 3,
    parameter int SAMPLE_BITS = 16,
    parameter int TAP_BITS    = 17
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [2:0]                      cfg_index,
    input  logic [4:0]                      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[3:0], pos_y[7:4], pos_z[10:8], tap_index[13:11], value[30:14], zero[31]
    input  logic [gfr_pkg::TDATA_IN_W-1:0]  s_tdata,
    // opcode[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // filtered_value[15:0]
    output logic [gfr_pkg::TDATA_OUT_W-1:0] m_tdata,
    // saturated[0]
    output logic                            m_tuser
);

    gfr_pkg::cmd_t    cmd;
    gfr_pkg::status_t status;

    gfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    gfr_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_DEPTH   (MAX_DEPTH),
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TAP_BITS    (TAP_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[design/gfr_ram.sv]
// gfr_ram: generic single-port RAM with registered read data.
// No dependencies.
module gfr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[design/gfr_ctrl.sv]
// gfr_ctrl: sequencer for word decode and the tap walk of a filtered read.
// Depends on gfr_pkg.
module gfr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       opcode,
    input  gfr_pkg::status_t status,
    output gfr_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.tap_idx  = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (opcode)
                        gfr_pkg::OP_TAP:   cmd.wr_tap = 1'b1;
                        gfr_pkg::OP_VOXEL: cmd.wr_voxel = 1'b1;
                        gfr_pkg::OP_READ: begin
                            cmd.load   = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                cmd.issue = 1'b1;
                if (cnt_reg == status.last_tap) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            ST_DRAIN: state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_DONE;
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[design/gfr_datapath.sv]
// gfr_datapath: config registers, tap file, volume RAM, address mirror,
// multiply-accumulate, rounding and the result register. Depends on gfr_pkg, gfr_ram.
module gfr_datapath #(
    parameter int MAX_WIDTH   = 16,
    parameter int MAX_HEIGHT  = 16,
    parameter int MAX_DEPTH   = 8,
    parameter int MAX_RADIUS  = 3,
    parameter int SAMPLE_BITS = 16,
    parameter int TAP_BITS    = 17
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [2:0]                         cfg_index,
    input  logic [4:0]                         cfg_wdata,
    input  logic [gfr_pkg::TDATA_IN_W-1:0]     s_tdata,
    input  gfr_pkg::cmd_t                      cmd,
    output gfr_pkg::status_t                   status,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gfr_pkg::TDATA_OUT_W-1:0]    m_tdata,
    output logic                               m_tuser
);

    localparam int VOL_WORDS = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
    localparam int AW        = (VOL_WORDS > 1) ? $clog2(VOL_WORDS) : 1;
    localparam int TAP_WORDS = 2 * MAX_RADIUS + 1;
    localparam int TAP_STORE = (TAP_WORDS < 8) ? TAP_WORDS : 8;
    localparam int TI_W      = (TAP_STORE > 1) ? $clog2(TAP_STORE) : 1;
    localparam int PROD_W    = (SAMPLE_BITS + TAP_BITS > 64) ? 64 : SAMPLE_BITS + TAP_BITS;
    localparam int ACC_W     = (PROD_W + 3 > 64) ? 64 : PROD_W + 3;
    localparam int RW0       = (ACC_W < 64) ? ACC_W + 1 : 64;
    localparam int RW        = (RW0 < 33) ? 33 : RW0;
    localparam logic [32:0] SAMPLE_MAX = (33'd1 << SAMPLE_BITS) - 33'd1;

    // word fields
    logic [3:0]  in_x, in_y, in_tap;
    logic [2:0]  in_z;
    logic [16:0] in_value;
    assign in_x     = s_tdata[3:0];
    assign in_y     = s_tdata[7:4];
    assign in_z     = s_tdata[10:8];
    assign in_tap   = {1'b0, s_tdata[13:11]};
    assign in_value = s_tdata[30:14];

    // config
    logic [1:0] axis_reg, radius_reg;
    logic [4:0] width_reg, height_reg;
    logic [3:0] depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg   <= gfr_pkg::AXIS_X;
            radius_reg <= 2'd1;
            width_reg  <= 5'd16;
            height_reg <= 5'd16;
            depth_reg  <= 4'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gfr_pkg::CFG_AXIS:   axis_reg   <= cfg_wdata[1:0];
                gfr_pkg::CFG_RADIUS: radius_reg <= cfg_wdata[1:0];
                gfr_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata;
                gfr_pkg::CFG_HEIGHT: height_reg <= cfg_wdata;
                gfr_pkg::CFG_DEPTH:  depth_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    logic [1:0] r_eff;
    logic [4:0] w_eff, h_eff, d_eff;

    always_comb begin
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_reg;
        w_eff = width_reg;
        if (width_reg == '0) w_eff = 5'd1;
        else if (32'(width_reg) > MAX_WIDTH) w_eff = 5'(MAX_WIDTH);
        h_eff = height_reg;
        if (height_reg == '0) h_eff = 5'd1;
        else if (32'(height_reg) > MAX_HEIGHT) h_eff = 5'(MAX_HEIGHT);
        d_eff = {1'b0, depth_reg};
        if (depth_reg == '0) d_eff = 5'd1;
        else if (32'(depth_reg) > MAX_DEPTH) d_eff = 5'(MAX_DEPTH);
    end

    assign status.last_tap = {r_eff, 1'b0};

    // tap file
    logic [TAP_BITS-1:0] tap_reg [TAP_STORE];

    always_ff @(posedge aclk) begin
        if (cmd.wr_tap && (32'(in_tap) < TAP_WORDS)) begin
            tap_reg[in_tap[TI_W-1:0]] <= TAP_BITS'(in_value);
        end
    end

    // latched read coordinates
    logic [3:0] lat_x_reg, lat_y_reg;
    logic [2:0] lat_z_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lat_x_reg <= in_x;
            lat_y_reg <= in_y;
            lat_z_reg <= in_z;
        end
    end

    // neighbour address
    gfr_pkg::coord_t x_c, y_c, z_c, off, nx, ny, nz;
    logic [AW-1:0]   rd_addr, wr_addr, ram_addr;
    logic            wr_ok;

    always_comb begin
        x_c = (32'(lat_x_reg) >= MAX_WIDTH)  ? gfr_pkg::coord_t'(MAX_WIDTH - 1)
                                             : $signed({4'b0000, lat_x_reg});
        y_c = (32'(lat_y_reg) >= MAX_HEIGHT) ? gfr_pkg::coord_t'(MAX_HEIGHT - 1)
                                             : $signed({4'b0000, lat_y_reg});
        z_c = (32'(lat_z_reg) >= MAX_DEPTH)  ? gfr_pkg::coord_t'(MAX_DEPTH - 1)
                                             : $signed({5'b00000, lat_z_reg});
        off = $signed({5'b00000, cmd.tap_idx}) - $signed({6'b000000, r_eff});
        nx = x_c;
        ny = y_c;
        nz = z_c;
        case (axis_reg)
            gfr_pkg::AXIS_X: nx = gfr_pkg::mirror($signed({4'b0000, lat_x_reg}) + off, w_eff);
            gfr_pkg::AXIS_Y: ny = gfr_pkg::mirror($signed({4'b0000, lat_y_reg}) + off, h_eff);
            gfr_pkg::AXIS_Z: nz = gfr_pkg::mirror($signed({5'b00000, lat_z_reg}) + off, d_eff);
            default: ;
        endcase
        rd_addr = AW'((int'(nz) * MAX_HEIGHT + int'(ny)) * MAX_WIDTH + int'(nx));
        wr_addr = AW'((int'(in_z) * MAX_HEIGHT + int'(in_y)) * MAX_WIDTH + int'(in_x));
        wr_ok   = (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT)
               && (32'(in_z) < MAX_DEPTH);
        ram_addr = cmd.wr_voxel ? wr_addr : rd_addr;
    end

    logic [32:0]            sat_value;
    logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

    assign sat_value = ({16'b0, in_value} > SAMPLE_MAX) ? SAMPLE_MAX : {16'b0, in_value};
    assign ram_wdata = SAMPLE_BITS'(sat_value);

    gfr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (VOL_WORDS),
        .AW    (AW)
    ) u_volume (
        .aclk  (aclk),
        .we    (cmd.wr_voxel && wr_ok),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // multiply-accumulate pipeline
    logic [TAP_BITS-1:0] tap_q_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                v1_reg, v2_reg;

    always_ff @(posedge aclk) begin
        tap_q_reg <= tap_reg[cmd.tap_idx[TI_W-1:0]];
        prod_reg  <= PROD_W'(ram_rdata * tap_q_reg);
        if (cmd.load) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    // round half up, saturate
    logic [RW-1:0] rsum;
    logic          rsat;
    assign rsum = RW'(acc_reg) + RW'(32'h8000);
    assign rsat = |rsum[RW-1:32];

    logic [15:0] out_value_reg;
    logic        out_sat_reg, out_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_value_reg <= rsat ? 16'hFFFF : rsum[31:16];
            out_sat_reg   <= rsat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_sat_reg;

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// testbench: self-checking bench for axis_gaussian_filter_reflect. Streams tap,
// voxel and read words, predicts filtered voxels with a local volume model
// (typed rows give their own). Depends on gfr_pkg and the RTL under design/.
module testbench;

    localparam logic [1:0] OP_NONE   = 2'd3;
    localparam logic [1:0] AXIS_NONE = 2'd3;
    localparam int VOX_WORDS   = 2048;
    localparam int FILL_WORDS  = 512;
    localparam int TAP_COUNT   = 7;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 12;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [2:0]  z;
        logic [2:0]  ti;
        logic [16:0] val;
        logic        typed;
        logic [15:0] exp_val;
        logic        exp_sat;
    } word_t;

    typedef struct packed {
        logic [15:0] value;
        logic        sat;
    } filtered_t;

    typedef struct packed {
        logic [1:0] axis;
        logic [1:0] radius;
        logic [4:0] width;
        logic [4:0] height;
        logic [3:0] depth;
    } setting_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [2:0]                      cfg_index = '0;
    logic [4:0]                      cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [gfr_pkg::TDATA_IN_W-1:0]  s_tdata   = '0;
    logic [1:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [gfr_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                            m_tuser;

    axis_gaussian_filter_reflect i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the block: volume, kernel, registers
    logic [15:0] vox_mem [VOX_WORDS];
    logic [16:0] tap_mem [TAP_COUNT];
    logic [1:0]  flt_axis;
    logic [1:0]  flt_radius;
    logic [4:0]  flt_width;
    logic [4:0]  flt_height;
    logic [3:0]  flt_depth;

    filtered_t filtered_q [$];
    int fail_count      = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int sat_seen        = 0;
    int src_pct         = 0;
    int sink_pct        = 0;
    int hold_req        = 0;
    int hold_ack        = 0;
    int hold_left       = 0;

    // default registers: axis x, radius 1, 16 x 16 x 1
    word_t directed_rows [24] = '{
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd0, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd1, 17'h10000, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd2, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd3, 17'h0AAAA, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd6, 17'h15555, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd7, 17'h1FFFF, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_VOXEL, 4'd0,  4'd0,  3'd0, 3'd0, 17'h01234, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_READ,  4'd0,  4'd0,  3'd0, 3'd0, 17'h00000, 1'b1, 16'h1234, 1'b0},
        '{gfr_pkg::OP_VOXEL, 4'd15, 4'd15, 3'd1, 3'd0, 17'h10000, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_READ,  4'd15, 4'd15, 3'd1, 3'd7, 17'h1FFFF, 1'b1, 16'hFFFF, 1'b0},
        '{OP_NONE,           4'd15, 4'd15, 3'd7, 3'd7, 17'h1FFFF, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd0, 17'h1FFFF, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd1, 17'h1FFFF, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd2, 17'h1FFFF, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_VOXEL, 4'd1,  4'd0,  3'd0, 3'd0, 17'h0FFFF, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_VOXEL, 4'd0,  4'd0,  3'd0, 3'd0, 17'h0FFFF, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_READ,  4'd0,  4'd0,  3'd0, 3'd0, 17'h00000, 1'b1, 16'hFFFF, 1'b1},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd0, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd2, 17'h00000, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_READ,  4'd1,  4'd0,  3'd0, 3'd0, 17'h00000, 1'b1, 16'hFFFF, 1'b1},
        '{gfr_pkg::OP_TAP,   4'd0,  4'd0,  3'd0, 3'd1, 17'h08000, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_VOXEL, 4'd3,  4'd9,  3'd1, 3'd0, 17'h00001, 1'b0, 16'h0000, 1'b0},
        '{gfr_pkg::OP_READ,  4'd3,  4'd9,  3'd1, 3'd0, 17'h00000, 1'b1, 16'h0001, 1'b0},
        '{gfr_pkg::OP_READ,  4'd15, 4'd0,  3'd0, 3'd5, 17'h1ABCD, 1'b0, 16'h0000, 1'b0}
    };

    // z filtering stays within the two filled planes
    setting_t phase_cfg [PHASES] = '{
        '{gfr_pkg::AXIS_X, 2'd3, 5'd16, 5'd16, 4'd8},
        '{gfr_pkg::AXIS_Y, 2'd3, 5'd16, 5'd16, 4'd8},
        '{gfr_pkg::AXIS_Z, 2'd3, 5'd16, 5'd16, 4'd2},
        '{AXIS_NONE,       2'd2, 5'd16, 5'd16, 4'd8},
        '{gfr_pkg::AXIS_X, 2'd0, 5'd1,  5'd1,  4'd1},
        '{gfr_pkg::AXIS_Z, 2'd1, 5'd0,  5'd0,  4'd0},
        '{gfr_pkg::AXIS_Y, 2'd2, 5'd31, 5'd31, 4'd15},
        '{gfr_pkg::AXIS_X, 2'd3, 5'd5,  5'd7,  4'd3},
        '{gfr_pkg::AXIS_Z, 2'd3, 5'd16, 5'd16, 4'd2},
        '{gfr_pkg::AXIS_Y, 2'd1, 5'd9,  5'd2,  4'd8},
        '{gfr_pkg::AXIS_X, 2'd0, 5'd0,  5'd0,  4'd0},
        '{gfr_pkg::AXIS_X, 2'd0, 5'd0,  5'd0,  4'd0}
    };

    function automatic int fold_edge(int i, int n);
        int m;
        m = i;
        if (m < 0) begin
            m = -m - 1;
        end else if (m >= n) begin
            m = 2 * n - m - 1;
        end
        if (m < 0) begin
            m = 0;
        end
        if (m > n - 1) begin
            m = n - 1;
        end
        return m;
    endfunction

    function automatic int clip_size(int v, int hi);
        if (v < 1) begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic filtered_t filter_voxel(word_t wd);
        int w, h, d, r, k, nx, ny, nz;
        logic [39:0] acc;
        logic [39:0] rnd;
        filtered_t res;
        w   = clip_size(int'(flt_width), 16);
        h   = clip_size(int'(flt_height), 16);
        d   = clip_size(int'(flt_depth), 8);
        r   = int'(flt_radius);
        acc = '0;
        for (k = -r; k <= r; k++) begin
            nx = int'(wd.x);
            ny = int'(wd.y);
            nz = int'(wd.z);
            case (flt_axis)
                gfr_pkg::AXIS_X: nx = fold_edge(int'(wd.x) + k, w);
                gfr_pkg::AXIS_Y: ny = fold_edge(int'(wd.y) + k, h);
                gfr_pkg::AXIS_Z: nz = fold_edge(int'(wd.z) + k, d);
                default: ;
            endcase
            acc = acc + tap_mem[k + r] * vox_mem[(nz * 16 + ny) * 16 + nx];
        end
        rnd = (acc + 40'h8000) >> 16;
        res.sat   = (rnd > 40'd65535);
        res.value = res.sat ? 16'hFFFF : rnd[15:0];
        return res;
    endfunction

    // update the shadow state; returns 1 when the word yields a result
    function automatic bit model_accept(input word_t wd, output filtered_t res);
        res = '0;
        case (wd.op)
            gfr_pkg::OP_TAP: begin
                if (wd.ti < TAP_COUNT) begin
                    tap_mem[wd.ti] = wd.val;
                end
            end
            gfr_pkg::OP_VOXEL: begin
                vox_mem[{wd.z, wd.y, wd.x}] = (wd.val > 17'h0FFFF) ? 16'hFFFF : wd.val[15:0];
            end
            gfr_pkg::OP_READ: begin
                res = filter_voxel(wd);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic word_t random_word();
        word_t wd;
        int pick;
        wd      = '0;
        wd.x    = 4'($urandom);
        wd.y    = 4'($urandom);
        wd.z    = 3'($urandom);
        wd.ti   = 3'($urandom);
        wd.val  = 17'($urandom);
        pick    = $urandom_range(99);
        if (pick < 45) begin
            wd.op = gfr_pkg::OP_READ;
            wd.z  = 3'($urandom_range(1));
        end else if (pick < 82) begin
            wd.op = gfr_pkg::OP_VOXEL;
            if (pick < 78) begin
                wd.val = 17'($urandom_range(65535));
            end
        end else if (pick < 97) begin
            wd.op = gfr_pkg::OP_TAP;
            if (pick < 93) begin
                wd.val = 17'($urandom_range(17'h06000));
            end
        end else begin
            wd.op = OP_NONE;
        end
        return wd;
    endfunction

    task automatic send_word(input word_t wd);
        filtered_t res;
        while ($urandom_range(99) < src_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= wd.op;
        s_tdata  <= {1'b0, wd.val, wd.ti, wd.z, wd.y, wd.x};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (model_accept(wd, res)) begin
            if (wd.typed) begin
                res.value = wd.exp_val;
                res.sat   = wd.exp_sat;
            end
            filtered_q.insert(filtered_q.size(), res);
        end
    endtask

    // wait for all results, then let trailing writes finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic program_regs(input setting_t st);
        logic [2:0] idx  [5];
        logic [4:0] vals [5];
        int i;
        idx[0] = gfr_pkg::CFG_AXIS;   vals[0] = 5'(st.axis);
        idx[1] = gfr_pkg::CFG_RADIUS; vals[1] = 5'(st.radius);
        idx[2] = gfr_pkg::CFG_WIDTH;  vals[2] = st.width;
        idx[3] = gfr_pkg::CFG_HEIGHT; vals[3] = st.height;
        idx[4] = gfr_pkg::CFG_DEPTH;  vals[4] = 5'(st.depth);
        for (i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en  <= 1'b0;
        flt_axis   = st.axis;
        flt_radius = st.radius;
        flt_width  = st.width;
        flt_height = st.height;
        flt_depth  = st.depth;
    endtask

    always @(posedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= sink_pct);
        end
    end

    always @(posedge aclk) begin
        filtered_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (filtered_q.size() == 0) begin
                $error("unexpected result word: filtered_value %h saturated %b",
                       m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = filtered_q.pop_front();
                results_checked++;
                if (m_tuser) begin
                    sat_seen++;
                end
                if (m_tdata !== want.value) begin
                    $error("filtered_value: expected %h, got %h", want.value, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.sat) begin
                    $error("saturated: expected %b, got %b", want.sat, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int ph, n, t;
        word_t wd;
        idle_mode_t mode;
        repeat (2) @(posedge aclk);
        aresetn    <= 1'b1;
        flt_axis   = gfr_pkg::AXIS_X;
        flt_radius = 2'd1;
        flt_width  = 5'd16;
        flt_height = 5'd16;
        flt_depth  = 4'd1;

        // fill kernel and the two lowest z planes; reads stay inside them
        for (t = 0; t < TAP_COUNT; t++) begin
            wd    = random_word();
            wd.op = gfr_pkg::OP_TAP;
            wd.ti = 3'(t);
            send_word(wd);
        end
        for (n = 0; n < FILL_WORDS; n++) begin
            wd    = random_word();
            wd.op = gfr_pkg::OP_VOXEL;
            {wd.z, wd.y, wd.x} = 11'(n);
            send_word(wd);
        end

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i]);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            if (ph >= PHASES - 2) begin
                phase_cfg[ph] = {2'($urandom), 2'($urandom), 5'($urandom),
                                 5'($urandom), 4'($urandom)};
                if (phase_cfg[ph].axis == gfr_pkg::AXIS_Z) begin
                    phase_cfg[ph].depth = 4'($urandom_range(2));
                end
            end
            program_regs(phase_cfg[ph]);
            mode     = idle_mode_t'(ph % 4);
            src_pct  = (mode == IDLE_SRC) ? 75 : (mode == IDLE_BOTH) ? 7 : 0;
            sink_pct = (mode == IDLE_SINK) ? 75 : (mode == IDLE_BOTH) ? 7 : 0;
            if (ph == 0) begin
                hold_req++;
            end
            n = 0;
            while (n < 55) begin
                if ($urandom_range(9) == 0) begin
                    // fresh kernel, then reads against it
                    for (t = 0; t < TAP_COUNT; t++) begin
                        wd     = random_word();
                        wd.op  = gfr_pkg::OP_TAP;
                        wd.ti  = 3'(t);
                        wd.val = 17'($urandom_range(17'h05000));
                        send_word(wd);
                    end
                    n += TAP_COUNT;
                end else begin
                    wd = random_word();
                    send_word(wd);
                    if (wd.op != OP_NONE) begin
                        n++;
                    end
                end
            end
        end
        settle();

        if (filtered_q.size() != 0) begin
            $error("%0d filtered results never arrived", filtered_q.size());
            fail_count++;
        end
        $display("Covered %0d words over %0d register settings and four idle mixes,",
                 words_sent, PHASES + 1);
        $display("%0d filtered voxels checked (%0d saturated), one long output hold.",
                 results_checked, sat_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
design/gfr_pkg.sv
design/gfr_ram.sv
design/gfr_ctrl.sv
design/gfr_datapath.sv
design/axis_gaussian_filter_reflect.sv
dv/testbench.sv
